[design/huffman_table_decoder_assert.svh]
// assertion macros of the huffman table decoder
`ifndef HUFFMAN_TABLE_DECODER_ASSERT_SVH
`define HUFFMAN_TABLE_DECODER_ASSERT_SVH

// property must hold at every clock edge outside reset
`define HTE_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// expression must never be true outside reset
`define HTE_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error(msg);

`endif

[design/hte_pkg.sv]
// types and constants of the huffman table decoder
package hte_pkg;

	localparam int OP_W      = 2;
	localparam int INDEX_W   = 8;
	localparam int SYM_W     = 8;
	localparam int CODE_W    = 32;
	localparam int LEN_W     = 6;
	localparam int BYTE_W    = 8;
	localparam int SCOUNT_W  = 9;
	localparam int OCOUNT_W  = 32;
	localparam int CFG_W     = 32;
	localparam int REG_W     = 1;

	// table entries held by one cell of the chain, the last cell may hold fewer
	localparam int CELL_ENTRIES = 8;

	localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
	localparam logic [OP_W-1:0] OP_DATA    = 2'd1;
	localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

	localparam logic [REG_W-1:0] REG_SYMBOL_COUNT = 1'b0;
	localparam logic [REG_W-1:0] REG_OUTPUT_COUNT = 1'b1;

	localparam logic [SCOUNT_W-1:0] SYMBOL_COUNT_RESET = 9'd256;

	// table write broadcast to every cell
	typedef struct packed {
		logic               en;
		logic [INDEX_W-1:0] index;
		logic [SYM_W-1:0]   symbol;
		logic [CODE_W-1:0]  code;
		logic [LEN_W-1:0]   length;
	} load_t;

	// lookup token and partial result handed from cell to cell
	typedef struct packed {
		logic             valid;
		logic             hit;
		logic [SYM_W-1:0] symbol;
		logic [LEN_W-1:0] longest;
		logic [LEN_W-1:0] count;
	} link_t;

endpackage

[design/hte_in_if.sv]
// input item channel of the huffman table decoder
interface hte_in_if import hte_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [OP_W-1:0]    op;
	logic [INDEX_W-1:0] entry_index;
	logic [SYM_W-1:0]   entry_symbol;
	logic [CODE_W-1:0]  entry_code;
	logic [LEN_W-1:0]   entry_length;
	logic [BYTE_W-1:0]  data_byte;

	modport source (
		output valid, op, entry_index, entry_symbol, entry_code, entry_length, data_byte,
		input  ready
	);

	modport sink (
		input  valid, op, entry_index, entry_symbol, entry_code, entry_length, data_byte,
		output ready
	);
endinterface

[design/hte_out_if.sv]
// result channel of the huffman table decoder
interface hte_out_if import hte_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [SYM_W-1:0] symbol;
	logic             matched;
	logic             last;
	logic             done_res;

	modport source (
		output valid, symbol, matched, last, done_res,
		input  ready
	);

	modport sink (
		input  valid, symbol, matched, last, done_res,
		output ready
	);
endinterface

[design/hte_cell.sv]
// chain cell: a slice of the code table, its matchers and one link register
module hte_cell import hte_pkg::*; #(
	parameter int BASE          = 0,
	parameter int ENTRIES       = 8,
	parameter int MAX_CODE_BITS = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  load_t                    load,
	input  logic [SCOUNT_W-1:0]      symbol_count,
	input  link_t                    link_i,
	input  logic [MAX_CODE_BITS-1:0] bits_i,
	output link_t                    link_o,
	output logic [MAX_CODE_BITS-1:0] bits_o
);

	logic [SYM_W-1:0]         sym_q  [ENTRIES];
	logic [MAX_CODE_BITS-1:0] code_q [ENTRIES];
	logic [LEN_W-1:0]         len_q  [ENTRIES];

	logic [ENTRIES-1:0] act;
	logic [ENTRIES-1:0] hit;
	logic               hit_l;
	logic [SYM_W-1:0]   sym_l;
	logic [LEN_W-1:0]   max_l;

	logic                     valid_q;
	logic                     hit_q;
	logic [SYM_W-1:0]         sym_out_q;
	logic [LEN_W-1:0]         longest_q;
	logic [LEN_W-1:0]         count_q;
	logic [MAX_CODE_BITS-1:0] bits_q;

	// table slice, undefined until loaded
	always_ff @(posedge clk) begin
		for (int e = 0; e < ENTRIES; e++) begin
			if (load.en && load.index == INDEX_W'(BASE + e)) begin
				sym_q[e]  <= load.symbol;
				code_q[e] <= load.code[MAX_CODE_BITS-1:0];
				len_q[e]  <= load.length;
			end
		end
	end

	// per-entry match against the gathered bits
	always_comb begin
		for (int e = 0; e < ENTRIES; e++) begin
			act[e] = (SCOUNT_W'(BASE + e) < symbol_count) && (len_q[e] != '0) &&
				(len_q[e] <= LEN_W'(MAX_CODE_BITS));
			hit[e] = act[e] && (len_q[e] == link_i.count) &&
				((code_q[e] & ~({MAX_CODE_BITS{1'b1}} << len_q[e])) == bits_i);
		end
	end

	// lowest index wins, earlier cells take precedence
	always_comb begin
		hit_l = 1'b0;
		sym_l = '0;
		max_l = link_i.longest;
		for (int e = ENTRIES - 1; e >= 0; e--) begin
			if (hit[e]) begin
				hit_l = 1'b1;
				sym_l = sym_q[e];
			end
		end
		for (int e = 0; e < ENTRIES; e++) begin
			if (act[e] && len_q[e] > max_l) begin
				max_l = len_q[e];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= link_i.valid;
		end
	end

	always_ff @(posedge clk) begin
		hit_q     <= link_i.hit || hit_l;
		sym_out_q <= link_i.hit ? link_i.symbol : sym_l;
		longest_q <= max_l;
		count_q   <= link_i.count;
		bits_q    <= bits_i;
	end

	assign link_o = '{valid: valid_q, hit: hit_q, symbol: sym_out_q,
		longest: longest_q, count: count_q};
	assign bits_o = bits_q;

endmodule

[design/huffman_table_decoder.sv]
// huffman table decoder top level: control, config registers and the cell chain
//
// item channel: op load writes one table entry, op data brings one compressed
// byte, op restart clears the gathered bits and the result count. loads,
// restarts and unknown ops give no result.
// result channel: one transfer per decoded symbol or no-match, last marks the
// final result of a byte, done_res marks the result that reaches output_count.
// config port: cfg_we writes symbol_count (index 0) or output_count (index 1).
// each compressed bit sends one lookup token down a chain of
// ceil(TABLE_DEPTH/8) cells, one cell per cycle, each checking up to 8 entries.
// one item is worked on at a time; the next is taken once the byte is done.
// a result is held back until the next result or the end of the byte decides
// its last flag, then sits in an output register; when the receiver stalls,
// decoding pauses only while both the held result and that register are full.
// reset clears the gathered bits and counters, sets symbol_count to 256 and
// output_count to 0; the code table is undefined until loaded.
`include "huffman_table_decoder_assert.svh"

module huffman_table_decoder import hte_pkg::*; #(
	parameter int TABLE_DEPTH   = 256,
	parameter int MAX_CODE_BITS = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	hte_in_if.sink           item,
	hte_out_if.source        result,
	input  logic             cfg_we,
	input  logic [REG_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	localparam int NCELL  = (TABLE_DEPTH + CELL_ENTRIES - 1) / CELL_ENTRIES;
	localparam int W      = MAX_CODE_BITS;
	localparam int BITS_W = $clog2(BYTE_W + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LAUNCH,
		ST_WAIT,
		ST_DECIDE,
		ST_FLUSH
	} state_t;

	state_t state_q;

	logic [SCOUNT_W-1:0] symbol_count_q;
	logic [OCOUNT_W-1:0] output_count_q;

	logic [BYTE_W-1:0]   byte_q;
	logic [BITS_W-1:0]   bits_left_q;
	logic [W-1:0]        gathered_q;
	logic [LEN_W-1:0]    count_q;
	logic [OCOUNT_W-1:0] produced_q;
	logic [W-1:0]        qbits_q;
	logic [LEN_W-1:0]    qcount_q;
	logic                res_hit_q;
	logic [SYM_W-1:0]    res_sym_q;
	logic [LEN_W-1:0]    res_longest_q;
	logic                pend_valid_q;
	logic [SYM_W-1:0]    pend_sym_q;
	logic                pend_matched_q;
	logic                pend_done_q;
	logic                out_valid_q;
	logic [SYM_W-1:0]    out_sym_q;
	logic                out_matched_q;
	logic                out_last_q;
	logic                out_done_q;

	load_t            load;
	link_t            link  [NCELL+1];
	logic [W-1:0]     bits  [NCELL+1];
	link_t            chain_out;
	logic [W-1:0]     next_bits;
	logic             stop;
	logic             emit;
	logic             can_push;
	logic             push;

	assign item.ready = (state_q == ST_IDLE);

	assign load = '{en: item.valid && item.ready && item.op == OP_LOAD,
		index: item.entry_index, symbol: item.entry_symbol,
		code: item.entry_code, length: item.entry_length};

	assign next_bits = {gathered_q[W-2:0], byte_q[BYTE_W-1]};
	assign stop      = (produced_q >= output_count_q);
	assign emit      = res_hit_q || (qcount_q >= res_longest_q);
	assign can_push  = !out_valid_q || result.ready;
	assign push      = pend_valid_q && can_push &&
		((state_q == ST_DECIDE && emit) || state_q == ST_FLUSH);

	assign link[0] = '{valid: state_q == ST_LAUNCH && !stop, hit: 1'b0, symbol: '0,
		longest: '0, count: count_q + LEN_W'(1)};
	assign bits[0] = next_bits;

	for (genvar k = 0; k < NCELL; k++) begin : g_cell
		localparam int BASE = k * CELL_ENTRIES;
		localparam int ENT  = (TABLE_DEPTH - BASE < CELL_ENTRIES) ?
			(TABLE_DEPTH - BASE) : CELL_ENTRIES;

		hte_cell #(
			.BASE          (BASE),
			.ENTRIES       (ENT),
			.MAX_CODE_BITS (MAX_CODE_BITS)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.load         (load),
			.symbol_count (symbol_count_q),
			.link_i       (link[k]),
			.bits_i       (bits[k]),
			.link_o       (link[k+1]),
			.bits_o       (bits[k+1])
		);
	end

	assign chain_out = link[NCELL];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			symbol_count_q <= SYMBOL_COUNT_RESET;
			output_count_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SYMBOL_COUNT: symbol_count_q <= cfg_data[SCOUNT_W-1:0];
				REG_OUTPUT_COUNT: output_count_q <= cfg_data[OCOUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			byte_q         <= '0;
			bits_left_q    <= '0;
			gathered_q     <= '0;
			count_q        <= '0;
			produced_q     <= '0;
			qbits_q        <= '0;
			qcount_q       <= '0;
			res_hit_q      <= 1'b0;
			res_sym_q      <= '0;
			res_longest_q  <= '0;
			pend_valid_q   <= 1'b0;
			pend_sym_q     <= '0;
			pend_matched_q <= 1'b0;
			pend_done_q    <= 1'b0;
			out_valid_q    <= 1'b0;
			out_sym_q      <= '0;
			out_matched_q  <= 1'b0;
			out_last_q     <= 1'b0;
			out_done_q     <= 1'b0;
		end else begin
			if (push) begin
				out_valid_q   <= 1'b1;
				out_sym_q     <= pend_sym_q;
				out_matched_q <= pend_matched_q;
				out_done_q    <= pend_done_q;
				out_last_q    <= (state_q == ST_FLUSH);
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (item.valid) begin
						case (item.op)
							OP_RESTART: begin
								gathered_q <= '0;
								count_q    <= '0;
								produced_q <= '0;
							end
							OP_DATA: begin
								byte_q      <= item.data_byte;
								bits_left_q <= BITS_W'(BYTE_W);
								state_q     <= ST_LAUNCH;
							end
							default: ;
						endcase
					end
				end
				ST_LAUNCH: begin
					if (stop) begin
						state_q <= ST_FLUSH;
					end else begin
						qbits_q     <= next_bits;
						qcount_q    <= count_q + LEN_W'(1);
						byte_q      <= byte_q << 1;
						bits_left_q <= bits_left_q - BITS_W'(1);
						state_q     <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (chain_out.valid) begin
						res_hit_q     <= chain_out.hit;
						res_sym_q     <= chain_out.symbol;
						res_longest_q <= chain_out.longest;
						state_q       <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (!emit) begin
						gathered_q <= qbits_q;
						count_q    <= qcount_q;
						state_q    <= (bits_left_q == '0) ? ST_FLUSH : ST_LAUNCH;
					end else if (!pend_valid_q || can_push) begin
						pend_valid_q   <= 1'b1;
						pend_sym_q     <= res_hit_q ? res_sym_q : '0;
						pend_matched_q <= res_hit_q;
						pend_done_q    <= (produced_q + OCOUNT_W'(1) == output_count_q);
						produced_q     <= produced_q + OCOUNT_W'(1);
						gathered_q     <= '0;
						count_q        <= '0;
						state_q        <= (bits_left_q == '0) ? ST_FLUSH : ST_LAUNCH;
					end
				end
				ST_FLUSH: begin
					if (!pend_valid_q) begin
						state_q <= ST_IDLE;
					end else if (can_push) begin
						pend_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign result.valid    = out_valid_q;
	assign result.symbol   = out_sym_q;
	assign result.matched  = out_matched_q;
	assign result.last     = out_last_q;
	assign result.done_res = out_done_q;

	`HTE_ASSERT(a_token_only_in_wait, chain_out.valid |-> state_q == ST_WAIT, "token left chain outside wait")
	`HTE_ASSERT(a_emit_below_count, (state_q == ST_DECIDE && emit) |-> produced_q < output_count_q, "result past output count")
	`HTE_NEVER(a_idle_holds_pending, state_q == ST_IDLE && pend_valid_q, "pending result left at idle")
	`HTE_ASSERT(a_launch_within_code, link[0].valid |-> count_q < LEN_W'(MAX_CODE_BITS), "gathered count beyond code width")

endmodule
